[rtl/core/assert_macros.svh]
// Assertion helpers for the bit packer block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

[rtl/core/bfpu_pkg.sv]
// ----------------------------------------------------------------------------
// bfpu_pkg
// Kinds, bit codes, the L/H pattern and the position width of the bit packer and unpacker.
// ----------------------------------------------------------------------------
package bfpu_pkg;
    localparam logic [2:0] KIND_WRITE = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_SET   = 3'd2;
    localparam logic [2:0] KIND_GETLH = 3'd3;
    localparam logic [2:0] KIND_FIND  = 3'd4;
    localparam logic [2:0] KIND_NTH   = 3'd5;
    localparam logic [2:0] KIND_PAD   = 3'd6;
    localparam logic [1:0] CODE_ZERO = 2'd0;
    localparam logic [1:0] CODE_ONE  = 2'd1;
    localparam logic [1:0] CODE_L    = 2'd2;
    localparam logic [1:0] CODE_H    = 2'd3;
    localparam logic [7:0] LH_PATTERN = 8'h2b;
    localparam int POS_W = 10;
endpackage

[rtl/core/bit_field_packer_unpacker_top.sv]
// ----------------------------------------------------------------------------
// bit_field_packer_unpacker_top
// MSB-first bit store with cursor, field read/write, bit set and L/H test, search and L/H padding.
// ----------------------------------------------------------------------------
// Requests arrive on s_axis (tdata: kind, use_cursor, position, field_length,
// write_value, bit_code, target from the lowest bit up). One result per
// request leaves on m_axis (status, read_data, found, found_position,
// cursor_after). cfg_we/cfg_wdata write bytes_in_use; write it only while no
// request is in flight.
// One shared bit unit walks the store one bit at a time. In each bit visit the
// byte is fetched into a read register, then modified and written back. A
// request makes at most field_length (capped at MAX_FIELD_BITS) plus one
// visits for a field, one for a single bit or an unused kind, and up to the
// bits scanned plus one for a search or pad (at most 513 with the full store).
// The result is registered as the unit leaves its done state for idle, where
// s_axis_tready returns, so a new request is taken only once the last is through.
// A request is accepted whenever the bit unit is idle, even while a result
// still waits; its own result then waits in the unit until the output register
// is taken, so a stalled receiver holds the result and delays the next one.
// Reset (synchronous, aresetn low) clears the store in STORE_BYTES cycles
// during which no request is accepted; the cursor resets to zero and
// bytes_in_use to 64.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bit_field_packer_unpacker_top #(
    parameter int STORE_BYTES = 64,
    parameter int MAX_FIELD_BITS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // kind[2:0], use_cursor[3], position[13:4], field_length[20:14],
    // write_value[84:21], bit_code[86:85], target[96:87], zero fill
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[0], read_data[64:1], found[65], found_position[75:66],
    // cursor_after[85:76], zero fill
    output logic [87:0]  m_axis_tdata
);
    import bfpu_pkg::*;

    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int LIM_W = 11;
    localparam logic [2:0] ST_CLR = 3'd0, ST_IDLE = 3'd1, ST_FETCH = 3'd2, ST_RUN = 3'd3,
                           ST_DONE = 3'd4;

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rdbyte_reg;      // registered store read
    logic [2:0] state_reg;
    logic [AW-1:0] clr_reg;
    logic [6:0] biu_reg;
    logic [POS_W-1:0] cursor_reg;
    logic [POS_W:0] pos_reg;     // current bit, one extra bit for wrap-free compare
    logic [6:0] cnt_reg;         // bits left for field ops
    logic [POS_W:0] nth_reg;
    logic [2:0] kind_reg;
    logic uc_reg;
    logic [63:0] wval_reg, rd_reg;
    logic [1:0] code_reg;
    logic [POS_W-1:0] tgt_reg;
    logic st_reg, fnd_reg;
    logic [POS_W-1:0] fpos_reg;
    logic out_v_reg;
    logic [87:0] out_reg;

    logic [LIM_W-1:0] lim;
    logic [6:0] biu_sat;
    assign biu_sat = (biu_reg > 7'(STORE_BYTES)) ? 7'(STORE_BYTES) : biu_reg;
    assign lim = {1'b0, biu_sat, 3'b000};

    // one bit unit: address, bit select, store byte
    logic [AW-1:0] addr;
    logic [2:0] sh;
    logic cur_bit, pat_bit, beyond;
    logic [POS_W-4:0] byte_idx;
    logic [6:0] cnt_m1;
    assign byte_idx = pos_reg[POS_W-1:3];
    // bytes inside the limit always lie below STORE_BYTES
    assign addr = byte_idx[AW-1:0];
    assign sh = 3'd7 - pos_reg[2:0];
    assign cur_bit = rdbyte_reg[sh];
    assign pat_bit = LH_PATTERN[sh];
    assign beyond = {1'b0, pos_reg} >= 12'(lim);
    assign cnt_m1 = cnt_reg - 7'd1;

    logic done, wr_en, wr_bit;
    logic [POS_W-1:0] cur_next;
    logic [63:0] rd_next;
    logic st_next, fnd_next;
    logic [POS_W-1:0] fpos_next;
    logic [POS_W:0] nth_next;

    always_comb begin
        done = 1'b0; wr_en = 1'b0; wr_bit = 1'b0;
        cur_next = cursor_reg; rd_next = rd_reg; st_next = st_reg;
        fnd_next = fnd_reg; fpos_next = fpos_reg; nth_next = nth_reg;
        case (kind_reg)
            KIND_WRITE, KIND_READ: begin
                if (cnt_reg == 7'd0) begin
                    done = 1'b1;
                end else if (beyond) begin
                    done = 1'b1; st_next = 1'b1;
                    if (kind_reg == KIND_READ) rd_next = '0;
                end else begin
                    if (kind_reg == KIND_WRITE) begin
                        wr_en = 1'b1; wr_bit = wval_reg[cnt_m1[5:0]];
                    end else begin
                        rd_next = {rd_reg[62:0], cur_bit};
                    end
                    cur_next = cursor_reg + 10'd1;
                end
            end
            KIND_SET: begin
                done = 1'b1;
                if (beyond) st_next = 1'b1;
                else begin
                    wr_en = 1'b1;
                    case (code_reg)
                        CODE_ZERO: wr_bit = 1'b0;
                        CODE_ONE:  wr_bit = 1'b1;
                        CODE_L:    wr_bit = pat_bit;
                        default:   wr_bit = ~pat_bit;
                    endcase
                    if (uc_reg) cur_next = pos_reg[POS_W-1:0] + 10'd1;
                end
            end
            KIND_GETLH: begin
                done = 1'b1;
                if (beyond) st_next = 1'b1;
                else begin
                    rd_next = {63'd0, cur_bit == ~pat_bit};
                    if (uc_reg) cur_next = pos_reg[POS_W-1:0] + 10'd1;
                end
            end
            KIND_FIND: begin
                if (code_reg[1] || beyond) done = 1'b1;
                else if (cur_bit == code_reg[0]) begin
                    done = 1'b1; fnd_next = 1'b1; fpos_next = pos_reg[POS_W-1:0];
                end
            end
            KIND_NTH: begin
                if (beyond) done = 1'b1;
                else if (cur_bit) begin
                    nth_next = nth_reg + 11'd1;
                    if (nth_next == {1'b0, tgt_reg}) begin
                        done = 1'b1; fnd_next = 1'b1; fpos_next = pos_reg[POS_W-1:0];
                    end
                end
            end
            KIND_PAD: begin
                if (pos_reg > {1'b0, tgt_reg} || beyond) done = 1'b1;
                else begin
                    wr_en = 1'b1; wr_bit = pat_bit;
                    cur_next = cursor_reg + 10'd1;
                end
            end
            default: done = 1'b1;
        endcase
    end

    logic [POS_W-1:0] start;
    logic [6:0] len_in;
    logic out_load;
    assign start = s_axis_tdata[3] ? cursor_reg : s_axis_tdata[13:4];
    assign len_in = (s_axis_tdata[20:14] > 7'(MAX_FIELD_BITS)) ? 7'(MAX_FIELD_BITS)
                                                               : s_axis_tdata[20:14];
    assign out_load = (state_reg == ST_DONE) && (!out_v_reg || m_axis_tready);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata = out_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLR) mem[clr_reg] <= 8'd0;
        else if (state_reg == ST_RUN && wr_en) begin
            mem[addr] <= (rdbyte_reg & ~(8'd1 << sh)) | (8'(wr_bit) << sh);
        end
        rdbyte_reg <= mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR; clr_reg <= '0; biu_reg <= 7'd64;
            cursor_reg <= '0; out_v_reg <= 1'b0;
        end else begin
            if (cfg_we) biu_reg <= cfg_wdata;
            if (out_load) out_v_reg <= 1'b1;
            else if (m_axis_tready) out_v_reg <= 1'b0;
            case (state_reg)
                ST_CLR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(STORE_BYTES - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        kind_reg <= s_axis_tdata[2:0]; uc_reg <= s_axis_tdata[3];
                        pos_reg <= (s_axis_tdata[2:0] == KIND_NTH) ? '0 : {1'b0, start};
                        cnt_reg <= len_in;
                        wval_reg <= s_axis_tdata[84:21]; code_reg <= s_axis_tdata[86:85];
                        tgt_reg <= s_axis_tdata[96:87];
                        rd_reg <= '0; st_reg <= 1'b0; fnd_reg <= 1'b0; fpos_reg <= '0;
                        nth_reg <= '0;
                        if (s_axis_tdata[2:0] == KIND_WRITE || s_axis_tdata[2:0] == KIND_READ
                            || s_axis_tdata[2:0] == KIND_PAD) cursor_reg <= start;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    cursor_reg <= cur_next; rd_reg <= rd_next; st_reg <= st_next;
                    fnd_reg <= fnd_next; fpos_reg <= fpos_next; nth_reg <= nth_next;
                    pos_reg <= pos_reg + 11'd1;
                    cnt_reg <= (cnt_reg == 7'd0) ? 7'd0 : cnt_reg - 7'd1;
                    // a search running off the end of the index range stops there
                    if (done || (pos_reg == 11'd1023 && (kind_reg == KIND_FIND
                        || kind_reg == KIND_NTH))) state_reg <= ST_DONE;
                    else state_reg <= ST_FETCH;
                end
                ST_DONE: begin
                    if (out_load) begin
                        out_reg <= {2'b00, cursor_reg, fpos_reg, fnd_reg, rd_reg, st_reg};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_CLR;
            endcase
        end
    end

    logic in_fire, out_stall;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    `ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != ST_IDLE, !s_axis_tready)
    `ASSERT_NEXT(a_accept_runs, aclk, aresetn, in_fire, state_reg == ST_FETCH)
    `ASSERT_NEXT(a_hold, aclk, aresetn, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

[bench/tb_bit_field_packer_unpacker_top.sv]
// ----------------------------------------------------------------------------
// tb_bit_field_packer_unpacker_top
// Drives field, bit, search and pad requests into the bit packer. A local
// model of the byte store and cursor predicts each result. The byte limit is
// changed between phases, and in some phases both sides idle at random rates.
// ----------------------------------------------------------------------------
module tb_bit_field_packer_unpacker_top;
    import bfpu_pkg::*;

    typedef struct packed {
        logic [9:0]  target;
        logic [1:0]  bit_code;
        logic [63:0] write_value;
        logic [6:0]  field_length;
        logic [9:0]  position;
        logic        use_cursor;
        logic [2:0]  kind;
    } request_t;

    typedef struct packed {
        logic [9:0]  cursor_after;
        logic [9:0]  found_position;
        logic        found;
        logic [63:0] read_data;
        logic        status;
    } result_t;

    class bit_store_board;
        logic [7:0] store_bytes [64];
        logic [9:0] cur;
        int unsigned limit_bytes;
        result_t pending [$];
        int mismatches;

        function new();
            foreach (store_bytes[i]) store_bytes[i] = 8'h00;
            cur = 0;
            limit_bytes = 64;
            mismatches = 0;
        endfunction

        function int unsigned lim_bits();
            lim_bits = (limit_bytes > 64 ? 64 : limit_bytes) * 8;
        endfunction

        function logic get_bit(int unsigned p);
            get_bit = store_bytes[(p / 8) % 64][7 - (p % 8)];
        endfunction

        function logic lh_bit(int unsigned p, logic high);
            lh_bit = LH_PATTERN[7 - (p % 8)] ^ high;
        endfunction

        function bit put_bit(int unsigned p, logic [1:0] code);
            logic v;
            if (p >= lim_bits()) return 0;
            case (code)
                CODE_ZERO: v = 1'b0;
                CODE_ONE:  v = 1'b1;
                CODE_L:    v = lh_bit(p, 1'b0);
                default:   v = lh_bit(p, 1'b1);
            endcase
            store_bytes[(p / 8) % 64][7 - (p % 8)] = v;
            return 1;
        endfunction

        function void note_request(request_t rq);
            result_t r;
            int unsigned start, len, lim, c, k;
            r = '0;
            lim = lim_bits();
            start = rq.use_cursor ? 32'(cur) : 32'(rq.position);
            len = rq.field_length > 64 ? 64 : 32'(rq.field_length);
            c = 32'(cur);
            case (rq.kind)
                KIND_WRITE: begin
                    c = start;
                    for (int i = 0; i < len; i++) begin
                        if (!put_bit(c, {1'b0, rq.write_value[len - 1 - i]})) begin
                            r.status = 1;
                            break;
                        end
                        c++;
                    end
                end
                KIND_READ: begin
                    c = start;
                    for (int i = 0; i < len; i++) begin
                        if (c >= lim) begin
                            r.status = 1;
                            r.read_data = 0;
                            break;
                        end
                        r.read_data[len - 1 - i] = get_bit(c);
                        c++;
                    end
                end
                KIND_SET: begin
                    if (!put_bit(start, rq.bit_code)) r.status = 1;
                    else if (rq.use_cursor) c = start + 1;
                end
                KIND_GETLH: begin
                    if (start >= lim) r.status = 1;
                    else begin
                        r.read_data = 64'(get_bit(start) == lh_bit(start, 1'b1));
                        if (rq.use_cursor) c = start + 1;
                    end
                end
                KIND_FIND: begin
                    if (rq.bit_code <= CODE_ONE)
                        for (int unsigned i = start; i < lim; i++)
                            if (get_bit(i) == rq.bit_code[0]) begin
                                r.found = 1;
                                r.found_position = 10'(i);
                                break;
                            end
                end
                KIND_NTH: begin
                    k = 0;
                    for (int unsigned i = 0; i < lim; i++)
                        if (get_bit(i)) begin
                            k++;
                            if (k == rq.target) begin
                                r.found = 1;
                                r.found_position = 10'(i);
                                break;
                            end
                        end
                end
                KIND_PAD: begin
                    c = start;
                    while (c <= rq.target) begin
                        if (!put_bit(c, CODE_L)) break;
                        c++;
                    end
                end
                default: ;
            endcase
            cur = c[9:0];
            r.cursor_after = cur;
            pending.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t exp;
            bit bad;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            exp = pending.pop_front();
            bad = exp.status != got.status || exp.read_data != got.read_data ||
                  exp.found != got.found || exp.found_position != got.found_position ||
                  exp.cursor_after != got.cursor_after;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp st=%0d rd=%h f=%0d fp=%0d cur=%0d",
                             exp.status, exp.read_data, exp.found, exp.found_position,
                             exp.cursor_after);
                    $display("          got st=%0d rd=%h f=%0d fp=%0d cur=%0d",
                             got.status, got.read_data, got.found, got.found_position,
                             got.cursor_after);
                end
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_we = 0;
    logic [6:0]   cfg_wdata = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [87:0]  m_axis_tdata;

    int send_idle_pct = 0;
    int take_idle_pct = 0;
    bit_store_board board = new();

    bit_field_packer_unpacker_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // receiver: sample at the edge, then pick a fresh ready
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= take_idle_pct);
    end

    // hold valid across back-to-back requests, drop it only while idling
    task automatic send_request(request_t rq);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {7'b0, rq};
        do @(posedge aclk); while (!s_axis_tready);
        board.note_request(rq);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (1200) @(posedge aclk);
    endtask

    task automatic set_limit(logic [6:0] v);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        board.limit_bytes = 32'(v);
        cfg_we <= 0;
    endtask

    function automatic request_t mk(logic [2:0] kind, logic uc, logic [9:0] pos,
                                    logic [6:0] len, logic [63:0] wv,
                                    logic [1:0] code, logic [9:0] tgt);
        request_t rq;
        rq.kind = kind; rq.use_cursor = uc; rq.position = pos; rq.field_length = len;
        rq.write_value = wv; rq.bit_code = code; rq.target = tgt;
        return rq;
    endfunction

    function automatic request_t random_request(int unsigned lim);
        request_t rq;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        rq = raw[$bits(request_t)-1:0];
        rq.kind = 3'($urandom_range(7));
        if ($urandom_range(3) != 0) rq.position = 10'($urandom_range(lim + 15));
        if ($urandom_range(3) != 0) rq.field_length = 7'($urandom_range(24));
        if ($urandom_range(3) != 0) rq.target = rq.position + 10'($urandom_range(40));
        if (rq.kind == KIND_NTH && $urandom_range(1)) rq.target = 10'($urandom_range(40));
        return rq;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send_request(random_request(board.lim_bits()));
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: extremes, every kind, L/H, faults beyond the limit
        send_request(mk(KIND_WRITE, 0, 0, 64, 64'hffff_ffff_ffff_ffff, 0, 0));
        send_request(mk(KIND_READ, 0, 0, 64, 0, 0, 0));
        send_request(mk(KIND_WRITE, 1, 0, 127, 64'h8000_0000_0000_0001, 0, 0));
        send_request(mk(KIND_READ, 0, 60, 0, 0, 0, 0));
        send_request(mk(KIND_WRITE, 0, 1020, 10, 64'h3ff, 0, 0));
        send_request(mk(KIND_READ, 0, 508, 8, 0, 0, 0));
        send_request(mk(KIND_SET, 1, 0, 0, 0, CODE_L, 0));
        send_request(mk(KIND_SET, 1, 0, 0, 0, CODE_H, 0));
        send_request(mk(KIND_SET, 0, 700, 0, 0, CODE_ONE, 0));
        send_request(mk(KIND_SET, 0, 5, 0, 0, CODE_ZERO, 0));
        send_request(mk(KIND_GETLH, 0, 0, 0, 0, 0, 0));
        send_request(mk(KIND_GETLH, 1, 0, 0, 0, 0, 0));
        send_request(mk(KIND_GETLH, 0, 1023, 0, 0, 0, 0));
        send_request(mk(KIND_FIND, 0, 0, 0, 0, CODE_ZERO, 0));
        send_request(mk(KIND_FIND, 0, 130, 0, 0, CODE_ONE, 0));
        send_request(mk(KIND_FIND, 0, 0, 0, 0, CODE_H, 0));
        send_request(mk(KIND_FIND, 0, 900, 0, 0, CODE_ONE, 0));
        send_request(mk(KIND_NTH, 0, 0, 0, 0, 0, 0));
        send_request(mk(KIND_NTH, 0, 0, 0, 0, 0, 3));
        send_request(mk(KIND_NTH, 0, 0, 0, 0, 0, 1023));
        send_request(mk(KIND_PAD, 0, 100, 0, 0, 0, 140));
        send_request(mk(KIND_PAD, 0, 200, 0, 0, 0, 100));
        send_request(mk(KIND_PAD, 0, 500, 0, 0, 0, 1023));
        send_request(mk(3'd7, 0, 0, 0, 0, 0, 0));
        wait_drained();

        send_idle_pct = 19; take_idle_pct = 76;
        set_limit(7'd0);
        random_phase(30);
        wait_drained();
        set_limit(7'd127);
        random_phase(100);
        wait_drained();

        send_idle_pct = 76; take_idle_pct = 19;
        set_limit(7'd3);
        random_phase(80);
        wait_drained();
        set_limit(7'd64);
        random_phase(40);

        send_idle_pct = 0; take_idle_pct = 0;
        random_phase(80);
        wait_drained();
        set_limit(7'd17);
        random_phase(80);
        wait_drained();

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
